>>> rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types, constants and helpers for the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int JOY_W     = 8;   // joystick sample width
    localparam int PWR_W     = 8;   // wheel power width
    localparam int MAG_W     = 7;   // power magnitude width
    localparam int NUM_W     = 14;  // dividend width of the restoring dividers
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam int AXES      = 3;
    localparam int WHEELS    = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_JOY_DEADBAND = 8'd0;
    localparam t_cfg_idx CFG_JOY_FULL     = 8'd1;
    localparam t_cfg_idx CFG_DRIVE_LOW    = 8'd2;
    localparam t_cfg_idx CFG_DRIVE_HIGH   = 8'd3;
    localparam t_cfg_idx CFG_STRAFE_LOW   = 8'd4;
    localparam t_cfg_idx CFG_STRAFE_HIGH  = 8'd5;
    localparam t_cfg_idx CFG_TURN_LOW     = 8'd6;
    localparam t_cfg_idx CFG_TURN_HIGH    = 8'd7;

    // Reciprocal of 3 for magnitudes up to 381: floor(x / 3) == (x * 171) >> 9
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;

    typedef enum logic [1:0] {
        MODE_DEAD,
        MODE_CLAMP,
        MODE_MAP
    } t_axis_mode;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [MAG_W-1:0] quo;
    } t_div_pair;

    typedef struct packed {
        logic             neg;
        t_axis_mode       mode;
        logic [MAG_W-1:0] low;
        logic [MAG_W-1:0] high;
        logic             hl_neg;
        t_div_pair        div;
    } t_axis_div;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        t_div_pair        div;
    } t_wheel_div;

    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic             scale;
    } t_scale_ctl;

    // One restoring division step producing quotient bit k.
    function automatic t_div_pair div_step(t_div_pair cur, logic [7:0] den, logic [2:0] k);
        t_div_pair       nxt;
        logic [NUM_W:0]  dsh;
        nxt = cur;
        dsh = ({7'd0, den} << k);
        if ({1'b0, cur.rem} >= dsh) begin
            nxt.rem    = NUM_W'({1'b0, cur.rem} - dsh);
            nxt.quo[k] = 1'b1;
        end
        return nxt;
    endfunction

endpackage

>>> rtl/mecanum_wheel_mixer_core.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_core
// Shapes three joystick axes and mixes them into four mecanum wheel powers.
// ----------------------------------------------------------------------------
// Nine-stage pipeline: one joystick sample set per cycle whenever the output side
// is not stalled. Stage 1 finds each axis's region and forms the mapping
// product, stages 2-3 divide it by (joy_full - joy_deadband) as a restoring
// divider, three and four quotient bits per stage. Stage 4 finishes the axis
// shaping, stage 5 mixes and divides by 3, stage 6 finds the largest wheel
// magnitude and forms p * MOTOR_LIMIT, stages 7-8 divide that by the maximum,
// stage 9 is the output register. Each stage holds under backpressure on its
// own, so bubbles are squeezed out. Configuration writes are always ready and
// take effect at once; write them only while the pipeline is empty.
module mecanum_wheel_mixer_core #(
    parameter int unsigned MOTOR_LIMIT = 100
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mwm_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // joystick samples
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [mwm_pkg::JOY_W-1:0]     i_forward_in,
    input  logic signed [mwm_pkg::JOY_W-1:0]     i_strafe_in,
    input  logic signed [mwm_pkg::JOY_W-1:0]     i_turn_in,
    // wheel powers
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mwm_pkg::PWR_W-1:0]     o_front_left_power,
    output logic signed [mwm_pkg::PWR_W-1:0]     o_front_right_power,
    output logic signed [mwm_pkg::PWR_W-1:0]     o_back_left_power,
    output logic signed [mwm_pkg::PWR_W-1:0]     o_back_right_power
);
    import mwm_pkg::*;

    localparam int            STAGES = 9;
    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(MOTOR_LIMIT);

    // ---------------- configuration ----------------
    logic [6:0]       r_joy_db;
    logic [7:0]       r_joy_full;
    logic [MAG_W-1:0] r_low  [AXES];
    logic [MAG_W-1:0] r_high [AXES];
    logic [7:0]       den;
    logic             den_zero;

    assign o_cfg_ready = 1'b1;
    assign den         = r_joy_full - {1'b0, r_joy_db};
    assign den_zero    = (den == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joy_db   <= 7'd10;
            r_joy_full <= 8'd127;
            r_low[0]   <= 7'd0;
            r_high[0]  <= 7'd100;
            r_low[1]   <= 7'd0;
            r_high[1]  <= 7'd100;
            r_low[2]   <= 7'd0;
            r_high[2]  <= 7'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_JOY_DEADBAND: r_joy_db   <= i_cfg_data[6:0];
                CFG_JOY_FULL:     r_joy_full <= i_cfg_data;
                CFG_DRIVE_LOW:    r_low[0]   <= i_cfg_data[6:0];
                CFG_DRIVE_HIGH:   r_high[0]  <= i_cfg_data[6:0];
                CFG_STRAFE_LOW:   r_low[1]   <= i_cfg_data[6:0];
                CFG_STRAFE_HIGH:  r_high[1]  <= i_cfg_data[6:0];
                CFG_TURN_LOW:     r_low[2]   <= i_cfg_data[6:0];
                CFG_TURN_HIGH:    r_high[2]  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [STAGES:1] r_vld;
    logic [STAGES:1] rdy;

    assign rdy[STAGES] = !r_vld[STAGES] || i_out_ready;
    for (genvar k = 1; k < STAGES; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_vld[STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: region and mapping product ----------------
    logic [JOY_W-1:0] s0_in [AXES];
    t_axis_div        n_s1  [AXES];
    t_axis_div        r_s1  [AXES];

    assign s0_in[0] = i_forward_in;
    assign s0_in[1] = i_strafe_in;
    assign s0_in[2] = i_turn_in;

    always_comb begin
        logic [7:0]       m;
        logic [7:0]       diff;
        logic [MAG_W-1:0] hl_mag;
        logic [14:0]      prod;
        for (int a = 0; a < AXES; a++) begin
            m      = s0_in[a][7] ? 8'(-s0_in[a]) : s0_in[a];   // -128 gives 128
            diff   = m - {1'b0, r_joy_db};
            hl_mag = (r_high[a] < r_low[a]) ? (r_low[a] - r_high[a])
                                            : (r_high[a] - r_low[a]);
            prod   = {7'd0, diff} * {8'd0, hl_mag};

            n_s1[a].neg     = s0_in[a][7];
            n_s1[a].low     = r_low[a];
            n_s1[a].high    = r_high[a];
            n_s1[a].hl_neg  = (r_high[a] < r_low[a]);
            n_s1[a].div.quo = '0;
            n_s1[a].div.rem = '0;
            if (m < {1'b0, r_joy_db}) begin
                n_s1[a].mode = MODE_DEAD;
            end else if (m > r_joy_full) begin
                n_s1[a].mode = MODE_CLAMP;
            end else begin
                n_s1[a].mode    = MODE_MAP;
                n_s1[a].div.rem = prod[NUM_W-1:0];
            end
        end
    end

    // ---------------- stages 2-3: divide by mapping span ----------------
    t_axis_div n_s2 [AXES];
    t_axis_div r_s2 [AXES];
    t_axis_div n_s3 [AXES];
    t_axis_div r_s3 [AXES];

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_s2[a] = r_s1[a];
            for (int k = 6; k >= 4; k--) begin
                n_s2[a].div = div_step(n_s2[a].div, den, 3'(k));
            end
            n_s3[a] = r_s2[a];
            for (int k = 3; k >= 0; k--) begin
                n_s3[a].div = div_step(n_s3[a].div, den, 3'(k));
            end
        end
    end

    // ---------------- stage 4: shaped axis value ----------------
    logic [7:0] n_s4 [AXES];
    logic [7:0] r_s4 [AXES];

    always_comb begin
        logic [MAG_W-1:0] q;
        logic [MAG_W-1:0] r;
        for (int a = 0; a < AXES; a++) begin
            // empty span: the only mapped magnitude sits on the edge, low power
            q = den_zero ? '0 : r_s3[a].div.quo;
            case (r_s3[a].mode)
                MODE_DEAD:  r = '0;
                MODE_CLAMP: r = r_s3[a].high;
                MODE_MAP:   r = r_s3[a].hl_neg ? (r_s3[a].low - q) : (r_s3[a].low + q);
                default:    r = '0;
            endcase
            n_s4[a] = r_s3[a].neg ? 8'(-{1'b0, r}) : {1'b0, r};
        end
    end

    // ---------------- stage 5: mix and divide by 3 ----------------
    logic             n_s5_neg [WHEELS];
    logic [MAG_W-1:0] n_s5_mag [WHEELS];
    logic             r_s5_neg [WHEELS];
    logic [MAG_W-1:0] r_s5_mag [WHEELS];

    always_comb begin
        logic signed [9:0] f;
        logic signed [9:0] s;
        logic signed [9:0] t;
        logic signed [9:0] mix [WHEELS];
        logic [8:0]        m9;
        logic [16:0]       prod;
        f = {{2{r_s4[0][7]}}, r_s4[0]};
        s = {{2{r_s4[1][7]}}, r_s4[1]};
        t = {{2{r_s4[2][7]}}, r_s4[2]};
        mix[0] = -f - s - t;
        mix[1] =  f - s - t;
        mix[2] = -f + s - t;
        mix[3] =  f + s - t;
        for (int w = 0; w < WHEELS; w++) begin
            m9          = mix[w][9] ? 9'(-mix[w]) : 9'(mix[w]);
            prod        = {8'd0, m9} * 17'(DIV3_MUL);
            n_s5_neg[w] = mix[w][9];
            n_s5_mag[w] = prod[DIV3_SHIFT +: MAG_W];
        end
    end

    // ---------------- stage 6: peak magnitude and scaled dividend ----------------
    t_wheel_div n_s6 [WHEELS];
    t_wheel_div r_s6 [WHEELS];
    t_scale_ctl n_s6_ctl;
    t_scale_ctl r_s6_ctl;

    always_comb begin
        logic [MAG_W-1:0] mx01;
        logic [MAG_W-1:0] mx23;
        logic [13:0]      prod;
        mx01 = (r_s5_mag[0] > r_s5_mag[1]) ? r_s5_mag[0] : r_s5_mag[1];
        mx23 = (r_s5_mag[2] > r_s5_mag[3]) ? r_s5_mag[2] : r_s5_mag[3];
        n_s6_ctl.mx    = (mx01 > mx23) ? mx01 : mx23;
        n_s6_ctl.scale = (n_s6_ctl.mx > LIMIT);
        for (int w = 0; w < WHEELS; w++) begin
            prod             = {7'd0, r_s5_mag[w]} * {7'd0, LIMIT};
            n_s6[w].neg      = r_s5_neg[w];
            n_s6[w].mag      = r_s5_mag[w];
            n_s6[w].div.rem  = prod[NUM_W-1:0];
            n_s6[w].div.quo  = '0;
        end
    end

    // ---------------- stages 7-8: divide by peak magnitude ----------------
    t_wheel_div n_s7 [WHEELS];
    t_wheel_div r_s7 [WHEELS];
    t_wheel_div n_s8 [WHEELS];
    t_wheel_div r_s8 [WHEELS];
    t_scale_ctl r_s7_ctl;
    t_scale_ctl r_s8_ctl;

    always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
            n_s7[w] = r_s6[w];
            for (int k = 6; k >= 4; k--) begin
                n_s7[w].div = div_step(n_s7[w].div, {1'b0, r_s6_ctl.mx}, 3'(k));
            end
            n_s8[w] = r_s7[w];
            for (int k = 3; k >= 0; k--) begin
                n_s8[w].div = div_step(n_s8[w].div, {1'b0, r_s7_ctl.mx}, 3'(k));
            end
        end
    end

    // ---------------- stage 9: output register ----------------
    logic [PWR_W-1:0] n_out [WHEELS];
    logic [PWR_W-1:0] r_out [WHEELS];

    always_comb begin
        logic [MAG_W-1:0] v;
        for (int w = 0; w < WHEELS; w++) begin
            v        = r_s8_ctl.scale ? r_s8[w].div.quo : r_s8[w].mag;
            n_out[w] = r_s8[w].neg ? PWR_W'(-{1'b0, v}) : {1'b0, v};
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (rdy[1]) r_s1 <= n_s1;
        if (rdy[2]) r_s2 <= n_s2;
        if (rdy[3]) r_s3 <= n_s3;
        if (rdy[4]) r_s4 <= n_s4;
        if (rdy[5]) begin
            r_s5_neg <= n_s5_neg;
            r_s5_mag <= n_s5_mag;
        end
        if (rdy[6]) begin
            r_s6     <= n_s6;
            r_s6_ctl <= n_s6_ctl;
        end
        if (rdy[7]) begin
            r_s7     <= n_s7;
            r_s7_ctl <= r_s6_ctl;
        end
        if (rdy[8]) begin
            r_s8     <= n_s8;
            r_s8_ctl <= r_s7_ctl;
        end
        if (rdy[9]) r_out <= n_out;
    end

    assign o_front_left_power  = r_out[0];
    assign o_front_right_power = r_out[1];
    assign o_back_left_power   = r_out[2];
    assign o_back_right_power  = r_out[3];

endmodule

>>> rtl/mwm_checker.sv
// ----------------------------------------------------------------------------
// mwm_checker
// Port-level checks for the mecanum wheel mixer, bound to the top level.
// ----------------------------------------------------------------------------
module mwm_checker #(
    parameter int unsigned MOTOR_LIMIT = 100
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic signed [7:0] o_front_left_power,
    input logic signed [7:0] o_front_right_power,
    input logic signed [7:0] o_back_left_power,
    input logic signed [7:0] o_back_right_power
);

    localparam int LIM = int'(MOTOR_LIMIT);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // with the output free, the pipeline must take a new sample
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side is free");

    // every wheel power stays within the motor limit
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_front_left_power  <= LIM && o_front_left_power  >= -LIM &&
             o_front_right_power <= LIM && o_front_right_power >= -LIM &&
             o_back_left_power   <= LIM && o_back_left_power   >= -LIM &&
             o_back_right_power  <= LIM && o_back_right_power  >= -LIM))
        else $error("wheel power beyond motor limit");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_front_left_power) && $stable(o_front_right_power) &&
             $stable(o_back_left_power) && $stable(o_back_right_power)))
        else $error("stalled result changed");

endmodule

bind mecanum_wheel_mixer_core mwm_checker #(
    .MOTOR_LIMIT (MOTOR_LIMIT)
) u_mwm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_front_left_power  (o_front_left_power),
    .o_front_right_power (o_front_right_power),
    .o_back_left_power   (o_back_left_power),
    .o_back_right_power  (o_back_right_power)
);

>>> bench/mecanum_wheel_mixer_core_tb.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_core_tb
// Drives joystick sample sets through the wheel mixer and compares every
// wheel power set with its typed value or a behavioral mixer kept in step
// with the registers. A short scripted run covers the extremes and register
// corner cases, then mostly randomly tuned phases follow with random idling
// on both channels and one long output stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwm_pkg::*;

    localparam int MOTOR_LIMIT   = 100;
    localparam int PIPE_DEPTH    = 9;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 100;
    localparam int AX_DRIVE      = 0;
    localparam int AX_STRAFE     = 1;
    localparam int AX_TURN       = 2;

    // indexes with no register behind them
    localparam t_cfg_idx IDX_SPARE_LO = 8'd8;
    localparam t_cfg_idx IDX_SPARE_HI = 8'hFF;

    localparam logic signed [JOY_W-1:0] STICK_MIN = 8'sh80;

    typedef struct packed {
        logic signed [PWR_W-1:0] fl;
        logic signed [PWR_W-1:0] fr;
        logic signed [PWR_W-1:0] bl;
        logic signed [PWR_W-1:0] br;
    } t_wheel_powers;

    typedef enum logic {
        ROW_REG,
        ROW_ITEM
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        t_cfg_idx                idx;
        logic [CFG_DAT_W-1:0]    data;
        logic signed [JOY_W-1:0] fwd;
        logic signed [JOY_W-1:0] side;
        logic signed [JOY_W-1:0] spin;
        logic                    typed;
        t_wheel_powers           want;
    } t_stim_row;

    localparam int SCRIPT_LEN = 53;

    // typed rows carry their wheel powers, the rest go through mix_wheels
    t_stim_row script [SCRIPT_LEN] = '{
        // reset settings
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd0, 8'sd0, 8'sd0, 1'b1,
          '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd127, 8'sd0, 8'sd0, 1'b1,
          '{-8'sd33, 8'sd33, -8'sd33, 8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, STICK_MIN, 8'sd0, 8'sd0, 1'b1,
          '{8'sd33, -8'sd33, 8'sd33, -8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd0, 8'sd127, 8'sd0, 1'b1,
          '{-8'sd33, -8'sd33, 8'sd33, 8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd0, 8'sd0, 8'sd127, 1'b1,
          '{-8'sd33, -8'sd33, -8'sd33, -8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd0, 8'sd0, STICK_MIN, 1'b1,
          '{8'sd33, 8'sd33, 8'sd33, 8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd127, 8'sd127, 8'sd127, 1'b1,
          '{-8'sd100, -8'sd33, -8'sd33, 8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, STICK_MIN, STICK_MIN, STICK_MIN, 1'b1,
          '{8'sd100, 8'sd33, 8'sd33, -8'sd33}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd9, -8'sd9, 8'sd9, 1'b1,
          '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd10, -8'sd10, 8'sd10, 1'b1,
          '{8'sd0, 8'sd0, 8'sd0, 8'sd0}},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd64, -8'sd37, 8'sd90, 1'b0, '0},
        // full power above the limit forces scaling; oversized data, dead indexes
        '{ROW_REG, CFG_DRIVE_HIGH, 8'hFF, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_HIGH, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_HIGH, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, IDX_SPARE_LO, 8'h00, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, IDX_SPARE_HI, 8'h37, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, -8'sd127, -8'sd127, -8'sd127, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd127, 8'sd127, STICK_MIN, 1'b0, '0},
        // empty mapping span
        '{ROW_REG, CFG_JOY_DEADBAND, 8'd50, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_JOY_FULL, 8'd50, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_LOW, 8'd20, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd50, -8'sd50, 8'sd49, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, STICK_MIN, 8'sd51, 8'sd0, 1'b0, '0},
        // deadband above full
        '{ROW_REG, CFG_JOY_DEADBAND, 8'd100, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_JOY_FULL, 8'd20, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd99, 8'sd100, -8'sd101, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd21, STICK_MIN, 8'sd127, 1'b0, '0},
        // high below low: downward maps
        '{ROW_REG, CFG_JOY_DEADBAND, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_JOY_FULL, 8'd128, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_LOW, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_HIGH, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_LOW, 8'd90, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_HIGH, 8'd5, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_LOW, 8'd60, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_HIGH, 8'd1, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd1, -8'sd1, 8'sd1, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, STICK_MIN, 8'sd77, -8'sd3, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd100, -8'sd100, 8'sd64, 1'b0, '0},
        // full beyond the stick range, widest power spans
        '{ROW_REG, CFG_JOY_FULL, 8'hFF, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_LOW, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_HIGH, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_LOW, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_HIGH, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_LOW, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_HIGH, 8'd127, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, STICK_MIN, 8'sd127, STICK_MIN, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd33, -8'sd66, 8'sd99, 1'b0, '0},
        // zero deadband and zero full: a centered stick gets its low power
        '{ROW_REG, CFG_JOY_FULL, 8'd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_DRIVE_LOW, 8'd5, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_STRAFE_LOW, 8'd5, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_REG, CFG_TURN_LOW, 8'd5, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
        '{ROW_ITEM, CFG_JOY_DEADBAND, 8'h00, -8'sd1, 8'sd1, 8'sd0, 1'b0, '0}
    };

    // register order for retuning the power ranges, low then high per axis
    t_cfg_idx power_regs [AXES*2] = '{
        CFG_DRIVE_LOW, CFG_DRIVE_HIGH,
        CFG_STRAFE_LOW, CFG_STRAFE_HIGH,
        CFG_TURN_LOW, CFG_TURN_HIGH
    };

    string wheel_name [WHEELS] = '{"front_left", "front_right", "back_left", "back_right"};

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    t_cfg_idx                i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]    i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic signed [JOY_W-1:0] i_forward_in = '0;
    logic signed [JOY_W-1:0] i_strafe_in  = '0;
    logic signed [JOY_W-1:0] i_turn_in    = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic signed [PWR_W-1:0] o_front_left_power;
    logic signed [PWR_W-1:0] o_front_right_power;
    logic signed [PWR_W-1:0] o_back_left_power;
    logic signed [PWR_W-1:0] o_back_right_power;

    // mirror of the register file, reset values
    logic [MAG_W-1:0] cfg_deadband = 7'd10;
    logic [7:0]       cfg_full     = 8'd127;
    logic [MAG_W-1:0] pwr_low  [AXES] = '{7'd0, 7'd0, 7'd0};
    logic [MAG_W-1:0] pwr_high [AXES] = '{7'd100, 7'd100, 7'd100};

    t_wheel_powers pending_powers [$];
    int            errors      = 0;
    int            idle_cycles = 0;
    bit            steady      = 1'b0;
    bit            hold_req    = 1'b0;
    int            hold_cycles = 0;

    mecanum_wheel_mixer_core #(
        .MOTOR_LIMIT(MOTOR_LIMIT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_forward_in       (i_forward_in),
        .i_strafe_in        (i_strafe_in),
        .i_turn_in          (i_turn_in),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_front_left_power (o_front_left_power),
        .o_front_right_power(o_front_right_power),
        .o_back_left_power  (o_back_left_power),
        .o_back_right_power (o_back_right_power)
    );

    always #2 i_clk = ~i_clk;

    function automatic int shape_stick(logic signed [JOY_W-1:0] raw, int lo, int hi);
        int v;
        int m;
        int db;
        int full;
        int r;
        v    = raw;
        m    = (v < 0) ? -v : v;
        db   = cfg_deadband;
        full = cfg_full;
        if (m < db)
            return 0;
        if (m > full)
            r = hi;
        else if (full - db <= 0)
            r = lo;
        else
            r = lo + ((m - db) * (hi - lo)) / (full - db);
        return (v < 0) ? -r : r;
    endfunction

    function automatic t_wheel_powers mix_wheels(logic signed [JOY_W-1:0] fwd,
                                                 logic signed [JOY_W-1:0] side,
                                                 logic signed [JOY_W-1:0] spin);
        int            f;
        int            s;
        int            t;
        int            p [WHEELS];
        int            peak;
        t_wheel_powers w;
        f = shape_stick(fwd, pwr_low[AX_DRIVE], pwr_high[AX_DRIVE]);
        s = shape_stick(side, pwr_low[AX_STRAFE], pwr_high[AX_STRAFE]);
        t = shape_stick(spin, pwr_low[AX_TURN], pwr_high[AX_TURN]);
        p[0] = (-f - s - t) / 3;
        p[1] = ( f - s - t) / 3;
        p[2] = (-f + s - t) / 3;
        p[3] = ( f + s - t) / 3;
        peak = 0;
        foreach (p[i])
            if ((p[i] < 0 ? -p[i] : p[i]) > peak)
                peak = (p[i] < 0) ? -p[i] : p[i];
        if (peak > MOTOR_LIMIT)
            foreach (p[i])
                p[i] = (p[i] * MOTOR_LIMIT) / peak;
        w.fl = PWR_W'(p[0]);
        w.fr = PWR_W'(p[1]);
        w.bl = PWR_W'(p[2]);
        w.br = PWR_W'(p[3]);
        return w;
    endfunction

    // biased toward the deadband and full-scale edges of the current settings
    function automatic logic signed [JOY_W-1:0] pick_stick();
        int m;
        case ($urandom_range(0, 5))
            0, 1: return JOY_W'($urandom);
            2: m = int'(cfg_deadband) + int'($urandom_range(0, 2)) - 1;
            3: m = int'(cfg_full) + int'($urandom_range(0, 2)) - 1;
            4: m = 127 + int'($urandom_range(0, 1));
            default: m = $urandom_range(0, 3);
        endcase
        if (m < 0)
            m = 0;
        if (m > 128)
            m = 128;
        if ($urandom_range(0, 1))
            return JOY_W'(-m);
        return JOY_W'((m > 127) ? 127 : m);
    endfunction

    // leaves valid high; the caller drops it once the group of writes is done
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_JOY_DEADBAND: cfg_deadband = data[MAG_W-1:0];
            CFG_JOY_FULL:     cfg_full = data;
            CFG_DRIVE_LOW:    pwr_low[AX_DRIVE] = data[MAG_W-1:0];
            CFG_DRIVE_HIGH:   pwr_high[AX_DRIVE] = data[MAG_W-1:0];
            CFG_STRAFE_LOW:   pwr_low[AX_STRAFE] = data[MAG_W-1:0];
            CFG_STRAFE_HIGH:  pwr_high[AX_STRAFE] = data[MAG_W-1:0];
            CFG_TURN_LOW:     pwr_low[AX_TURN] = data[MAG_W-1:0];
            CFG_TURN_HIGH:    pwr_high[AX_TURN] = data[MAG_W-1:0];
            default: ;
        endcase
    endtask

    // leaves valid high after the transfer; the next call or drain decides
    task automatic send_sample(logic signed [JOY_W-1:0] fwd, logic signed [JOY_W-1:0] side,
                               logic signed [JOY_W-1:0] spin, logic typed,
                               t_wheel_powers want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_forward_in <= fwd;
        i_strafe_in  <= side;
        i_turn_in    <= spin;
        do @(posedge i_clk); while (!o_in_ready);
        pending_powers.push_back(typed ? want : mix_wheels(fwd, side, spin));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge i_clk);
    endtask

    // style 0: widest spans, style 1: everything inverted, else random
    task automatic retune(int style);
        logic [7:0] db;
        logic [7:0] full;
        logic [7:0] v;
        case (style)
            0: begin
                db   = 8'd0;
                full = 8'd128;
            end
            1: begin
                db   = 8'd127;
                full = 8'd0;
            end
            default: begin
                if ($urandom_range(0, 3) != 0) begin
                    db   = 8'($urandom_range(0, 40));
                    full = 8'($urandom_range(int'(db) + 1, 128));
                end else begin
                    db   = 8'($urandom);
                    full = 8'($urandom);
                end
            end
        endcase
        write_reg(CFG_JOY_DEADBAND, db);
        write_reg(CFG_JOY_FULL, full);
        for (int k = 0; k < AXES * 2; k++) begin
            case (style)
                0: v = (k % 2) ? 8'd127 : 8'd0;
                1: v = (k % 2) ? 8'd0 : 8'd127;
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 8'd0;
                        1: v = 8'd127;
                        2: v = 8'($urandom_range(0, 127));
                        default: v = 8'($urandom);
                    endcase
                end
            endcase
            write_reg(power_regs[k], v);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(t_cfg_idx'($urandom_range(8, 255)), 8'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_REG) begin
                drain();
                write_reg(script[r].idx, script[r].data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_sample(script[r].fwd, script[r].side, script[r].spin,
                            script[r].typed, script[r].want);
            end
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            retune(ph);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // long output stall with the sender running flat out
                if (ph == 3 && n == 20) begin
                    steady      = 1'b1;
                    hold_cycles = 64;
                    hold_req    = 1'b1;
                end
                send_sample(pick_stick(), pick_stick(), pick_stick(), 1'b0, '0);
            end
        end

        drain();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // output side: random stalls per transfer, plus the requested long hold
    initial begin
        int stall;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    always @(posedge i_clk) begin : check_powers
        t_wheel_powers           want;
        logic signed [PWR_W-1:0] got    [WHEELS];
        logic signed [PWR_W-1:0] want_p [WHEELS];
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_front_left_power, o_front_right_power,
                    o_back_left_power, o_back_right_power};
            if (pending_powers.size() == 0) begin
                errors++;
                $display("%0t: unexpected wheel powers %0d %0d %0d %0d", $time,
                         got[0], got[1], got[2], got[3]);
            end else begin
                want   = pending_powers.pop_front();
                want_p = '{want.fl, want.fr, want.bl, want.br};
                for (int w = 0; w < WHEELS; w++)
                    if (got[w] !== want_p[w]) begin
                        errors++;
                        $display("%0t: %s power expected %0d got %0d", $time,
                                 wheel_name[w], want_p[w], got[w]);
                    end
            end
        end
    end

    // counts cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

>>> sim.f
rtl/mwm_pkg.sv
rtl/mecanum_wheel_mixer_core.sv
rtl/mwm_checker.sv
bench/mecanum_wheel_mixer_core_tb.sv
